>>> sv/grfg_pkg.sv
// shared types and constants of the gaussian row filter
package grfg_pkg;

    localparam int TAP_INDEX_W = 6;
    localparam int TAP_VALUE_W = 16;
    localparam int SAMPLE_W    = 16;
    localparam int RESULT_W    = 17;
    localparam int POS_W       = 6;
    localparam int RADIUS_W    = 5;
    localparam int CFG_INDEX_W = 1;
    localparam int CFG_DATA_W  = 5;

    localparam int FRAC_BITS  = 15;
    localparam int ROUND_BIAS = 1 << 14;
    localparam int SAT_MAX    = 32767;
    localparam int SAT_MIN    = -32768;

    localparam logic ACT_TAP    = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    localparam logic [CFG_INDEX_W-1:0] REG_KERNEL_RADIUS = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_GRADIENT_MODE = CFG_INDEX_W'(1);

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(3);

    typedef struct packed {
        logic                          action;
        logic [TAP_INDEX_W-1:0]        tap_index;
        logic [TAP_VALUE_W-1:0]        tap_value;
        logic signed [SAMPLE_W-1:0]    sample;
        logic                          row_last;
    } t_in_beat;

    typedef struct packed {
        logic signed [RESULT_W-1:0]    result_value;
        logic [POS_W-1:0]              position;
        logic                          row_error;
        logic                          out_last;
    } t_out_beat;

    typedef struct packed {
        logic start;
        logic err;
        logic grad;
    } t_diff_cmd;

endpackage

>>> sv/grfg_stream_if.sv
// valid/ready stream interface carrying one beat of payload
interface grfg_stream_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/gaussian_row_filter_gradient.sv
// top level of the gaussian row filter with optional gradient output
//
//   channel  dir  beat contents                                       handshake
//   i_in     in   action, tap_index, tap_value, sample, row_last      valid/ready
//   o_out    out  result_value, position, row_error, out_last         valid/ready
//   i_cfg    in   i_cfg_index, i_cfg_data                             i_cfg_we only
//
// a tap load or a sample push is taken only while idle; ready is low while a row is filtered
// a row of n samples and radius r runs 2r+1 taps per sample through the multiply-accumulate
// loop, one tap and one sample memory read per cycle, then two smoothed-memory reads per
// result (S_HI, S_LO) before S_EMIT; a short row skips smoothing and gives its error beat
// from S_ERR; reset is synchronous and active low; the memories need no clearing
// a stalled output holds its beat and pauses the result sequencer
module gaussian_row_filter_gradient #(
    parameter int MAX_RADIUS     = 16,
    parameter int MAX_ROW_LENGTH = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [grfg_pkg::CFG_INDEX_W-1:0] i_cfg_index,
    input  logic [grfg_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    grfg_stream_if.sink                      i_in,
    grfg_stream_if.source                    o_out
);
    import grfg_pkg::*;

    localparam int TAP_DEPTH = 2 * MAX_RADIUS + 1;
    localparam int TW        = $clog2(TAP_DEPTH);
    localparam int AW        = $clog2(MAX_ROW_LENGTH);
    localparam int CW        = $clog2(MAX_ROW_LENGTH + 1);
    localparam int RW        = $clog2(MAX_RADIUS + 1);

    typedef enum logic [1:0] {S_IDLE, S_SMOOTH, S_DIFF} t_state;

    t_state               r_state;
    logic [RADIUS_W-1:0]  r_kernel_radius;
    logic                 r_gradient_mode;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        r_len;
    logic [RW-1:0]        r_rad;
    logic                 r_smooth_go;
    t_diff_cmd            r_diff_cmd;

    logic                 w_accept;
    logic                 w_is_sample;
    logic                 w_room;
    logic [CW-1:0]        w_len_new;
    logic [RW-1:0]        w_rad_eff;
    logic                 w_short;
    logic                 w_tap_we;
    logic                 w_smp_we;
    logic                 w_sm_wr_en;
    logic [AW-1:0]        w_sm_wr_addr;
    logic signed [SAMPLE_W-1:0] w_sm_wr_data;
    logic                 w_smooth_done;
    logic                 w_diff_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel_radius <= RADIUS_RESET;
            r_gradient_mode <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_KERNEL_RADIUS: r_kernel_radius <= i_cfg_data[RADIUS_W-1:0];
                REG_GRADIENT_MODE: r_gradient_mode <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign i_in.ready  = (r_state == S_IDLE);
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_is_sample = w_accept && (i_in.payload.action == ACT_SAMPLE);
    assign w_room      = (int'(r_count) < MAX_ROW_LENGTH);
    assign w_len_new   = r_count + CW'(w_room);
    assign w_rad_eff   = (int'(r_kernel_radius) > MAX_RADIUS) ? RW'(MAX_RADIUS)
                                                              : RW'(r_kernel_radius);
    assign w_short     = (int'(w_len_new) < 2) || (int'(w_len_new) <= int'(w_rad_eff));

    assign w_tap_we = w_accept && (i_in.payload.action == ACT_TAP)
                      && (int'(i_in.payload.tap_index) < TAP_DEPTH);
    assign w_smp_we = w_is_sample && w_room;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_smooth_go <= 1'b0;
            r_diff_cmd  <= '0;
        end else begin
            r_smooth_go <= 1'b0;
            r_diff_cmd  <= '0;
            case (r_state)
                S_IDLE: begin
                    if (w_is_sample) begin
                        if (i_in.payload.row_last) begin
                            r_count <= '0;
                            r_len   <= w_len_new;
                            r_rad   <= w_rad_eff;
                            if (w_short) begin
                                r_diff_cmd <= '{start: 1'b1, err: 1'b1, grad: r_gradient_mode};
                                r_state    <= S_DIFF;
                            end else begin
                                r_smooth_go <= 1'b1;
                                r_state     <= S_SMOOTH;
                            end
                        end else begin
                            r_count <= w_len_new;
                        end
                    end
                end
                S_SMOOTH: begin
                    if (w_smooth_done) begin
                        r_diff_cmd <= '{start: 1'b1, err: 1'b0, grad: r_gradient_mode};
                        r_state    <= S_DIFF;
                    end
                end
                S_DIFF: begin
                    if (w_diff_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    grfg_smooth #(
        .MAX_RADIUS     (MAX_RADIUS),
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_smooth (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tap_we   (w_tap_we),
        .i_tap_addr (i_in.payload.tap_index[TW-1:0]),
        .i_tap_data (i_in.payload.tap_value),
        .i_smp_we   (w_smp_we),
        .i_smp_addr (r_count[AW-1:0]),
        .i_smp_data (i_in.payload.sample),
        .i_start    (r_smooth_go),
        .i_len      (r_len),
        .i_radius   (r_rad),
        .o_wr_en    (w_sm_wr_en),
        .o_wr_addr  (w_sm_wr_addr),
        .o_wr_data  (w_sm_wr_data),
        .o_done     (w_smooth_done)
    );

    grfg_diff #(
        .MAX_ROW_LENGTH (MAX_ROW_LENGTH)
    ) u_diff (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_sm_wr_en),
        .i_wr_addr (w_sm_wr_addr),
        .i_wr_data (w_sm_wr_data),
        .i_cmd     (r_diff_cmd),
        .i_len     (r_len),
        .o_done    (w_diff_done),
        .o_out     (o_out)
    );

endmodule

>>> sv/grfg_smooth.sv
// tap and sample memories with the multiply-accumulate sequencer
module grfg_smooth #(
    parameter int MAX_RADIUS     = 16,
    parameter int MAX_ROW_LENGTH = 64,
    localparam int TAP_DEPTH = 2 * MAX_RADIUS + 1,
    localparam int TW        = $clog2(TAP_DEPTH),
    localparam int AW        = $clog2(MAX_ROW_LENGTH),
    localparam int CW        = $clog2(MAX_ROW_LENGTH + 1),
    localparam int RW        = $clog2(MAX_RADIUS + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_tap_we,
    input  logic [TW-1:0]                        i_tap_addr,
    input  logic [grfg_pkg::TAP_VALUE_W-1:0]     i_tap_data,
    input  logic                                 i_smp_we,
    input  logic [AW-1:0]                        i_smp_addr,
    input  logic signed [grfg_pkg::SAMPLE_W-1:0] i_smp_data,
    input  logic                                 i_start,
    input  logic [CW-1:0]                        i_len,
    input  logic [RW-1:0]                        i_radius,
    output logic                                 o_wr_en,
    output logic [AW-1:0]                        o_wr_addr,
    output logic signed [grfg_pkg::SAMPLE_W-1:0] o_wr_data,
    output logic                                 o_done
);
    import grfg_pkg::*;

    localparam int IXW    = ((AW > TW) ? AW : TW) + 2;
    localparam int PROD_W = SAMPLE_W + TAP_VALUE_W + 1;
    localparam int ACC_W  = PROD_W + TW;

    typedef enum logic [1:0] {S_IDLE, S_ISSUE, S_DRAIN} t_state;

    t_state r_state;

    logic [TAP_VALUE_W-1:0]     r_tap_mem [TAP_DEPTH];
    logic signed [SAMPLE_W-1:0] r_smp_mem [MAX_ROW_LENGTH];
    logic [TAP_VALUE_W-1:0]     r_tap_q;
    logic signed [SAMPLE_W-1:0] r_smp_q;

    logic [AW-1:0] r_i;
    logic [TW-1:0] r_j;

    logic              r_p1_v, r_p1_first, r_p1_last, r_p1_end;
    logic [AW-1:0]     r_p1_i;
    logic              r_p2_v, r_p2_first, r_p2_last, r_p2_end;
    logic [AW-1:0]     r_p2_i;
    logic signed [PROD_W-1:0] r_prod;
    logic              r_p3_v, r_p3_last, r_p3_end;
    logic [AW-1:0]     r_p3_i;
    logic signed [ACC_W-1:0]  r_acc;

    logic                     w_issue;
    logic [TW-1:0]            w_two_r;
    logic                     w_tap_end;
    logic                     w_row_end;
    logic signed [IXW-1:0]    w_t;
    logic signed [IXW-1:0]    w_lenx;
    logic signed [IXW-1:0]    w_m;
    logic [AW-1:0]            w_idx;
    logic signed [PROD_W-1:0] w_sx;
    logic signed [PROD_W-1:0] w_tx;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [ACC_W-1:0]  w_sh;

    assign w_issue   = (r_state == S_ISSUE);
    assign w_two_r   = TW'({i_radius, 1'b0});
    assign w_tap_end = (r_j == w_two_r);
    assign w_row_end = (CW'(r_i) == i_len - CW'(1));

    // offset into the row with mirror reflection at both ends
    assign w_t    = $signed(IXW'(r_i)) + $signed(IXW'(r_j)) - $signed(IXW'(i_radius));
    assign w_lenx = $signed(IXW'(i_len));

    always_comb begin
        if (w_t < 0) begin
            w_m = -w_t;
        end else if (w_t >= w_lenx) begin
            w_m = (w_lenx <<< 1) - $signed(IXW'(2)) - w_t;
        end else begin
            w_m = w_t;
        end
    end

    assign w_idx = w_m[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_tap_we) begin
            r_tap_mem[i_tap_addr] <= i_tap_data;
        end
        if (w_issue) begin
            r_tap_q <= r_tap_mem[r_j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_smp_we) begin
            r_smp_mem[i_smp_addr] <= i_smp_data;
        end
        if (w_issue) begin
            r_smp_q <= r_smp_mem[w_idx];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_i     <= '0;
                        r_j     <= '0;
                        r_state <= S_ISSUE;
                    end
                end
                S_ISSUE: begin
                    if (w_tap_end) begin
                        r_j <= '0;
                        if (w_row_end) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i <= r_i + AW'(1);
                        end
                    end else begin
                        r_j <= r_j + TW'(1);
                    end
                end
                S_DRAIN: begin
                    if (o_done) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign w_sx = PROD_W'(r_smp_q);
    assign w_tx = PROD_W'({1'b0, r_tap_q});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1_v <= 1'b0;
            r_p2_v <= 1'b0;
            r_p3_v <= 1'b0;
        end else begin
            r_p1_v <= w_issue;
            r_p2_v <= r_p1_v;
            r_p3_v <= r_p2_v;
        end
        r_p1_first <= (r_j == '0);
        r_p1_last  <= w_tap_end;
        r_p1_end   <= w_row_end;
        r_p1_i     <= r_i;

        r_prod     <= w_sx * w_tx;
        r_p2_first <= r_p1_first;
        r_p2_last  <= r_p1_last;
        r_p2_end   <= r_p1_end;
        r_p2_i     <= r_p1_i;

        if (r_p2_v) begin
            r_acc <= r_p2_first ? ACC_W'(r_prod) : r_acc + ACC_W'(r_prod);
        end
        r_p3_last <= r_p2_last;
        r_p3_end  <= r_p2_end;
        r_p3_i    <= r_p2_i;
    end

    // round half up, then saturate to the sample range
    assign w_rnd = r_acc + ACC_W'(ROUND_BIAS);
    assign w_sh  = w_rnd >>> FRAC_BITS;

    always_comb begin
        if (w_sh > ACC_W'(SAT_MAX)) begin
            o_wr_data = SAMPLE_W'(SAT_MAX);
        end else if (w_sh < ACC_W'(SAT_MIN)) begin
            o_wr_data = SAMPLE_W'(SAT_MIN);
        end else begin
            o_wr_data = SAMPLE_W'(w_sh);
        end
    end

    assign o_wr_en   = r_p3_v && r_p3_last;
    assign o_wr_addr = r_p3_i;
    assign o_done    = o_wr_en && r_p3_end;

endmodule

>>> sv/grfg_diff.sv
// smoothed-row memory, difference stage and output register
module grfg_diff #(
    parameter int MAX_ROW_LENGTH = 64,
    localparam int AW = $clog2(MAX_ROW_LENGTH),
    localparam int CW = $clog2(MAX_ROW_LENGTH + 1)
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr_en,
    input  logic [AW-1:0]                        i_wr_addr,
    input  logic signed [grfg_pkg::SAMPLE_W-1:0] i_wr_data,
    input  grfg_pkg::t_diff_cmd                  i_cmd,
    input  logic [CW-1:0]                        i_len,
    output logic                                 o_done,
    grfg_stream_if.source                        o_out
);
    import grfg_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_HI, S_LO, S_EMIT, S_ERR} t_state;

    t_state r_state;

    logic signed [SAMPLE_W-1:0] r_sm_mem [MAX_ROW_LENGTH];
    logic signed [SAMPLE_W-1:0] r_rd;
    logic signed [SAMPLE_W-1:0] r_hi;
    logic [AW-1:0]              r_i;
    logic                       r_grad;
    t_out_beat                  r_out;
    logic                       r_out_valid;

    logic                       w_free;
    logic                       w_first_i;
    logic                       w_last_i;
    logic [AW-1:0]              w_hi_addr;
    logic [AW-1:0]              w_lo_addr;
    logic                       w_rd_en;
    logic [AW-1:0]              w_rd_addr;
    logic signed [RESULT_W-1:0] w_d;
    logic signed [RESULT_W-1:0] w_val;

    assign w_free    = !r_out_valid || o_out.ready;
    assign w_first_i = (r_i == '0);
    assign w_last_i  = (CW'(r_i) == i_len - CW'(1));

    assign w_hi_addr = (r_grad && !w_last_i) ? r_i + AW'(1) : r_i;
    assign w_lo_addr = (r_grad && !w_first_i) ? r_i - AW'(1) : r_i;

    assign w_rd_en   = (r_state == S_HI) || (r_state == S_LO);
    assign w_rd_addr = (r_state == S_HI) ? w_hi_addr : w_lo_addr;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_sm_mem[i_wr_addr] <= i_wr_data;
        end
        if (w_rd_en) begin
            r_rd <= r_sm_mem[w_rd_addr];
        end
    end

    // in gradient mode a halved central difference inside the row, one-sided at the ends; else the smoothed value
    assign w_d = RESULT_W'(r_hi) - RESULT_W'(r_rd);

    always_comb begin
        if (!r_grad) begin
            w_val = RESULT_W'(r_hi);
        end else if (w_first_i || w_last_i) begin
            w_val = w_d;
        end else begin
            w_val = w_d >>> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_cmd.start) begin
                        r_grad  <= i_cmd.grad;
                        r_i     <= '0;
                        r_state <= i_cmd.err ? S_ERR : S_HI;
                    end
                end
                S_HI: begin
                    r_state <= S_LO;
                end
                S_LO: begin
                    r_hi    <= r_rd;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (w_free) begin
                        r_out.result_value <= w_val;
                        r_out.position     <= POS_W'(r_i);
                        r_out.row_error    <= 1'b0;
                        r_out.out_last     <= w_last_i;
                        r_out_valid        <= 1'b1;
                        if (w_last_i) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_i     <= r_i + AW'(1);
                            r_state <= S_HI;
                        end
                    end
                end
                S_ERR: begin
                    if (w_free) begin
                        r_out.result_value <= '0;
                        r_out.position     <= '0;
                        r_out.row_error    <= 1'b1;
                        r_out.out_last     <= 1'b1;
                        r_out_valid        <= 1'b1;
                        r_state            <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done = w_free && (((r_state == S_EMIT) && w_last_i) || (r_state == S_ERR));

    assign o_out.valid   = r_out_valid;
    assign o_out.payload = r_out;

endmodule

>>> sv/grfg_checker.sv
// port-level assertions for the gaussian row filter and their bind
module grfg_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_in_ready,
    input  logic                i_in_action,
    input  logic                i_in_last,
    input  logic                i_out_valid,
    input  logic                i_out_ready,
    input  grfg_pkg::t_out_beat i_out_beat
);
    import grfg_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("output beat dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> $stable(i_out_beat))
        else $error("output beat changed while stalled");

    a_err_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_beat.row_error |->
            i_out_beat.out_last && (i_out_beat.position == '0)
            && (i_out_beat.result_value == '0))
        else $error("malformed error beat");

    a_busy_mid_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_beat.out_last |-> !i_in_ready)
        else $error("input taken while a row is still being emitted");

    a_row_end_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready && (i_in_action == ACT_SAMPLE) && i_in_last |=> !i_in_ready)
        else $error("input still ready after the row end beat");

endmodule

bind gaussian_row_filter_gradient grfg_checker u_grfg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_in_action (i_in.payload.action),
    .i_in_last   (i_in.payload.row_last),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_beat  (o_out.payload)
);

>>> verif/grfg_row_check_pkg.sv
// row filter predictor and result scoreboard for the gaussian row filter testbench
package grfg_row_check_pkg;

    import grfg_pkg::*;

    localparam int TAP_DEPTH  = 33;
    localparam int ROW_DEPTH  = 64;
    localparam int RADIUS_CAP = 16;

    class row_filter_scoreboard;
        logic [TAP_VALUE_W-1:0]     taps   [TAP_DEPTH];
        logic signed [SAMPLE_W-1:0] row    [ROW_DEPTH];
        logic signed [SAMPLE_W-1:0] smooth [ROW_DEPTH];
        int unsigned                row_len;
        logic [RADIUS_W-1:0]        radius;
        logic                       grad;
        t_out_beat                  expected_results [$];
        int unsigned                mismatches;

        function new();
            row_len    = 0;
            radius     = RADIUS_RESET;
            grad       = 1'b0;
            mismatches = 0;
            foreach (taps[k]) begin
                taps[k] = '0;
            end
        endfunction

        function void set_register(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [CFG_DATA_W-1:0] data);
            if (idx == REG_KERNEL_RADIUS) begin
                radius = data[RADIUS_W-1:0];
            end else if (idx == REG_GRADIENT_MODE) begin
                grad = data[0];
            end
        endfunction

        function void filter_row();
            int        n;
            int        r;
            int        k;
            int        j;
            int        idx;
            longint    acc;
            longint    v;
            t_out_beat res;
            n = row_len;
            r = (radius > RADIUS_CAP) ? RADIUS_CAP : int'(radius);
            if (n < 2 || n <= r) begin
                res.result_value = '0;
                res.position     = '0;
                res.row_error    = 1'b1;
                res.out_last     = 1'b1;
                expected_results.push_back(res);
            end else begin
                for (k = 0; k < n; k++) begin
                    acc = 0;
                    for (j = -r; j <= r; j++) begin
                        idx = k + j;
                        if (idx < 0) begin
                            idx = -idx;
                        end
                        if (idx >= n) begin
                            idx = 2 * n - idx - 2;
                        end
                        acc += longint'(row[idx]) * longint'({1'b0, taps[j + r]});
                    end
                    v = (acc + ROUND_BIAS) >>> FRAC_BITS;
                    if (v > SAT_MAX) begin
                        v = SAT_MAX;
                    end
                    if (v < SAT_MIN) begin
                        v = SAT_MIN;
                    end
                    smooth[k] = v[SAMPLE_W-1:0];
                end
                for (k = 0; k < n; k++) begin
                    if (!grad) begin
                        v = smooth[k];
                    end else if (k == 0) begin
                        v = longint'(smooth[1]) - longint'(smooth[0]);
                    end else if (k == n - 1) begin
                        v = longint'(smooth[n - 1]) - longint'(smooth[n - 2]);
                    end else begin
                        v = (longint'(smooth[k + 1]) - longint'(smooth[k - 1])) >>> 1;
                    end
                    res.result_value = v[RESULT_W-1:0];
                    res.position     = k[POS_W-1:0];
                    res.row_error    = 1'b0;
                    res.out_last     = (k == n - 1);
                    expected_results.push_back(res);
                end
            end
        endfunction

        function void note_beat(input t_in_beat b);
            if (b.action == ACT_TAP) begin
                if (b.tap_index < TAP_DEPTH) begin
                    taps[b.tap_index] = b.tap_value;
                end
            end else begin
                if (row_len < ROW_DEPTH) begin
                    row[row_len] = b.sample;
                    row_len++;
                end
                if (b.row_last) begin
                    filter_row();
                    row_len = 0;
                end
            end
        endfunction

        function void compare_field(input string name, input logic [RESULT_W-1:0] want,
                                    input logic [RESULT_W-1:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(input t_out_beat got);
            t_out_beat want;
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected beat, expected none, actual value %0h pos %0d err %0b last %0b",
                         $time, got.result_value, got.position, got.row_error, got.out_last);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                compare_field("result_value", want.result_value, got.result_value);
                compare_field("position", RESULT_W'(want.position), RESULT_W'(got.position));
                compare_field("row_error", RESULT_W'(want.row_error), RESULT_W'(got.row_error));
                compare_field("out_last", RESULT_W'(want.out_last), RESULT_W'(got.out_last));
            end
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction
    endclass

endpackage

>>> verif/gaussian_row_filter_gradient_test.sv
// self-checking testbench of the gaussian row filter with gradient output
module gaussian_row_filter_gradient_test;

    timeunit 1ns;
    timeprecision 1ps;

    import grfg_pkg::*;
    import grfg_row_check_pkg::*;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

    localparam int NUM_PHASES    = 12;
    localparam int PHASE_BEATS   = 16;
    localparam int SETTLE_CYCLES = 16;
    localparam int QUIET_LIMIT   = 20000;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int          phase_radius [NUM_PHASES] = '{5, 0, 16, 31, 2, 1, 16, 7, 31, 4, 0, 3};
    logic        phase_grad   [NUM_PHASES] = '{0, 1, 1, 0, 1, 0, 0, 1, 1, 0, 0, 1};
    idle_mode_e  phase_idle   [NUM_PHASES] = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                                               IDLE_NONE, IDLE_SEND, IDLE_BOTH, IDLE_RECV,
                                               IDLE_NONE, IDLE_BOTH, IDLE_RECV, IDLE_SEND};

    int unsigned send_idle_pct = 0;
    int unsigned stall_pct     = 0;
    int unsigned phase_beats   = 0;
    int unsigned quiet_cycles  = 0;

    row_filter_scoreboard scoreboard = new();

    grfg_stream_if #(.t_payload(t_in_beat))  in_if ();
    grfg_stream_if #(.t_payload(t_out_beat)) out_if ();

    gaussian_row_filter_gradient u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in        (in_if),
        .o_out       (out_if)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    initial begin : result_sink
        out_if.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (rst_n && out_if.valid && out_if.ready) begin
                scoreboard.check_result(out_if.payload);
            end
            out_if.ready <= (stall_pct == 0) || ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == QUIET_LIMIT) begin
            $display("gaussian_row_filter_gradient regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic t_in_beat tap_beat(input logic [TAP_INDEX_W-1:0] idx,
                                          input logic [TAP_VALUE_W-1:0] val);
        t_in_beat b;
        b.action    = ACT_TAP;
        b.tap_index = idx;
        b.tap_value = val;
        b.sample    = SAMPLE_W'($urandom);
        b.row_last  = 1'($urandom);
        return b;
    endfunction

    function automatic t_in_beat sample_beat(input logic [SAMPLE_W-1:0] s, input logic last);
        t_in_beat b;
        b.action    = ACT_SAMPLE;
        b.tap_index = TAP_INDEX_W'($urandom);
        b.tap_value = TAP_VALUE_W'($urandom);
        b.sample    = s;
        b.row_last  = last;
        return b;
    endfunction

    function automatic void set_idling(input idle_mode_e m);
        case (m)
            IDLE_NONE: begin
                send_idle_pct = 0;
                stall_pct     = 0;
            end
            IDLE_SEND: begin
                send_idle_pct = 75;
                stall_pct     = 0;
            end
            IDLE_RECV: begin
                send_idle_pct = 0;
                stall_pct     = 75;
            end
            default: begin
                send_idle_pct = 18;
                stall_pct     = 18;
            end
        endcase
    endfunction

    task automatic send_beat(input t_in_beat b);
        int unsigned gap;
        gap = 0;
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            in_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_if.valid   <= 1'b1;
        in_if.payload <= b;
        do begin
            @(posedge clk);
        end while (!in_if.ready);
        scoreboard.note_beat(b);
        phase_beats++;
    endtask

    task automatic drain_results();
        in_if.valid <= 1'b0;
        while (scoreboard.pending() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_settings(input logic [CFG_DATA_W-1:0] radius, input logic grad);
        cfg_we    <= 1'b1;
        cfg_index <= REG_KERNEL_RADIUS;
        cfg_data  <= radius;
        @(posedge clk);
        scoreboard.set_register(REG_KERNEL_RADIUS, radius);
        cfg_index <= REG_GRADIENT_MODE;
        cfg_data  <= CFG_DATA_W'(grad);
        @(posedge clk);
        scoreboard.set_register(REG_GRADIENT_MODE, CFG_DATA_W'(grad));
        cfg_we <= 1'b0;
    endtask

    task automatic run_directed();
        int k;
        // identity kernel at the reset radius
        for (k = 0; k < 7; k++) begin
            send_beat(tap_beat(TAP_INDEX_W'(k), (k == 3) ? 16'h8000 : 16'h0000));
        end
        // out of range tap indexes are dropped
        send_beat(tap_beat(6'd63, 16'hFFFF));
        send_beat(tap_beat(6'd33, 16'h1234));
        send_beat(sample_beat(16'h8000, 1'b0));
        send_beat(sample_beat(16'h7FFF, 1'b0));
        send_beat(sample_beat(16'h0000, 1'b0));
        send_beat(sample_beat(16'hFFFF, 1'b0));
        send_beat(sample_beat(16'h0001, 1'b1));
        // row no longer than the radius, then a single sample row
        send_beat(sample_beat(16'h1234, 1'b0));
        send_beat(sample_beat(16'hEDCB, 1'b0));
        send_beat(sample_beat(16'h0042, 1'b1));
        send_beat(sample_beat(16'h7FFF, 1'b1));
        // weights summing above one saturate
        send_beat(tap_beat(6'd3, 16'hFFFF));
        send_beat(tap_beat(6'd2, 16'h0001));
        send_beat(sample_beat(16'h7FFF, 1'b0));
        send_beat(sample_beat(16'h8000, 1'b0));
        send_beat(sample_beat(16'h7FFF, 1'b0));
        send_beat(sample_beat(16'h0064, 1'b0));
        send_beat(sample_beat(16'hFF9C, 1'b1));
    endtask

    task automatic load_kernel(input int reff);
        int unsigned            style;
        int unsigned            side_sum;
        int                     k;
        logic [TAP_VALUE_W-1:0] half [RADIUS_CAP+1];
        style    = $urandom_range(9);
        side_sum = 0;
        for (k = 0; k < reff; k++) begin
            if (style < 6) begin
                half[k] = TAP_VALUE_W'($urandom_range(0, 32768 / (2 * reff + 1)));
            end else if (style < 8) begin
                half[k] = TAP_VALUE_W'($urandom);
            end else begin
                half[k] = TAP_VALUE_W'($urandom_range(0, 32768));
            end
            side_sum += half[k];
        end
        if (style < 6) begin
            half[reff] = TAP_VALUE_W'(32768 - 2 * side_sum);
        end else if (style < 8) begin
            half[reff] = TAP_VALUE_W'($urandom);
        end else begin
            half[reff] = TAP_VALUE_W'($urandom_range(0, 32768));
        end
        for (k = 0; k <= 2 * reff; k++) begin
            send_beat(tap_beat(TAP_INDEX_W'(k), half[(k <= reff) ? k : 2 * reff - k]));
        end
    endtask

    task automatic send_row(input int reff);
        int                   len;
        int                   lo;
        int                   k;
        int unsigned          sel;
        logic [SAMPLE_W-1:0]  s;
        sel = $urandom_range(99);
        lo  = (reff + 1 > 2) ? reff + 1 : 2;
        if (sel < 12) begin
            len = $urandom_range(1, (reff > 1) ? reff : 1);
        end else if (sel < 15) begin
            len = $urandom_range(ROW_DEPTH, ROW_DEPTH + 6);
        end else begin
            len = lo + $urandom_range(0, 10);
            if (len > ROW_DEPTH) begin
                len = ROW_DEPTH;
            end
        end
        for (k = 0; k < len; k++) begin
            if ($urandom_range(99) < 4) begin
                send_beat(tap_beat(TAP_INDEX_W'($urandom), TAP_VALUE_W'($urandom)));
            end
            sel = $urandom_range(9);
            if (sel < 7) begin
                s = SAMPLE_W'($urandom);
            end else if (sel < 9) begin
                s = SAMPLE_W'($urandom_range(0, 600) - 300);
            end else begin
                s = $urandom_range(1) ? 16'h7FFF : 16'h8000;
            end
            send_beat(sample_beat(s, k == len - 1));
        end
    endtask

    initial begin : stimulus
        int ph;
        int reff;
        in_if.valid   <= 1'b0;
        in_if.payload <= '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        for (ph = 0; ph < NUM_PHASES; ph++) begin
            drain_results();
            apply_settings(CFG_DATA_W'(phase_radius[ph]), phase_grad[ph]);
            set_idling(phase_idle[ph]);
            reff        = (phase_radius[ph] > RADIUS_CAP) ? RADIUS_CAP : phase_radius[ph];
            phase_beats = 0;
            load_kernel(reff);
            // at least one row per phase, even after a wide kernel load
            do begin
                send_row(reff);
            end while (phase_beats < PHASE_BEATS);
        end
        drain_results();
        if (scoreboard.mismatches == 0) begin
            $display("gaussian_row_filter_gradient regression: pass");
        end else begin
            $display("gaussian_row_filter_gradient regression: fail");
        end
        $finish;
    end

endmodule
